### hdl/rrjq_pkg.sv
// Shared types and codes for the round-robin user job queue scheduler.
`default_nettype none

package rrjq_pkg;

    // Fixed field widths of the request and result channels
    localparam int USER_BITS    = 4;
    localparam int JOB_TAG_BITS = 16;
    localparam int STATUS_BITS  = 2;

    typedef logic [USER_BITS-1:0]    user_t;
    typedef logic [JOB_TAG_BITS-1:0] tag_t;

    // Request operation codes
    typedef enum logic
    {
        OP_ADD = 1'b0,
        OP_POP = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_DROP  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

endpackage

`default_nettype wire

### hdl/round_robin_user_job_queues_top.sv
// Round-robin scheduler over per-user job FIFOs held in on-chip RAM.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  request   | in_valid / in_stall  | operation, user_index, job_tag
//  result    | out_valid / out_stall| popped_valid, popped_job, popped_user,
//            |                      | pending, head_job, head_user, status
//
// One request at a time: a request runs from acceptance through the per-user meta RAM
// read, the modify step and, for a pop, the job store read; an add for a user beyond
// MAX_USERS or a pop on an empty ring goes straight to the ring head lookup.
// The sequence is set by the chain of registered reads: per-user meta RAM, then
// job store RAM, once for a popped job and once more for the new ring head.
// Reset: ring pointers and per-user valid bits clear at once, RAM contents need no pass.
// A stalled result waits in the output register while the next request runs;
// the sequencer holds only if that request finishes before the result leaves.
`default_nettype none

module round_robin_user_job_queues_top #(
    parameter int MAX_USERS   = 16,  // 2..16, user_index is four bits
    parameter int QUEUE_DEPTH = 16   // 2..1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // request channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 operation,
    input  wire rrjq_pkg::user_t                      user_index,
    input  wire rrjq_pkg::tag_t                       job_tag,
    // result channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      popped_valid,
    output rrjq_pkg::tag_t                            popped_job,
    output rrjq_pkg::user_t                           popped_user,
    output logic                                      pending,
    output rrjq_pkg::tag_t                            head_job,
    output rrjq_pkg::user_t                           head_user,
    output logic [rrjq_pkg::STATUS_BITS-1:0]          status
);

    import rrjq_pkg::*;

    localparam int UW  = $clog2(MAX_USERS);
    localparam int CW  = $clog2(MAX_USERS + 1);
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW  = QW + QCW;
    localparam int SD  = MAX_USERS * QUEUE_DEPTH;
    localparam int SAW = $clog2(SD);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_RDM,
        S_ACT,
        S_POPD,
        S_HRD,
        S_HMETA,
        S_HSTORE,
        S_OUT
    } state_t;

    // job store address of a user's queue slot
    function automatic logic [SAW-1:0] store_addr(input logic [UW-1:0] u,
                                                  input logic [QW-1:0] pos);
        store_addr = SAW'(u) * SAW'(QUEUE_DEPTH) + SAW'(pos);
    endfunction

    // sequencer and request registers
    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [UW-1:0]   cur_user_reg, cur_user_next;
    tag_t            tag_reg, tag_next;
    status_t         stat_reg, stat_next;
    tag_t            pj_reg, pj_next;
    logic [UW-1:0]   hu_reg, hu_next;
    tag_t            hj_reg, hj_next;
    logic            rd_vld_reg, rd_vld_next;
    logic            vld_reg [MAX_USERS];
    logic            vld_next [MAX_USERS];

    // service ring
    logic [UW-1:0]   ring_users_reg [MAX_USERS];
    logic [UW-1:0]   ring_users_next [MAX_USERS];
    logic [UW-1:0]   ring_front_reg, ring_front_next;
    logic [CW-1:0]   ring_count_reg, ring_count_next;

    // result register
    logic            out_valid_reg, out_valid_next;
    logic            popped_valid_reg, popped_valid_next;
    tag_t            popped_job_reg, popped_job_next;
    user_t           popped_user_reg, popped_user_next;
    logic            pending_reg, pending_next;
    tag_t            head_job_reg, head_job_next;
    user_t           head_user_reg, head_user_next;
    status_t         status_reg, status_next;

    // RAM ports
    logic            meta_we, meta_re;
    logic [UW-1:0]   meta_waddr, meta_raddr;
    logic [MW-1:0]   meta_wdata, meta_rdata;
    logic            store_we, store_re;
    logic [SAW-1:0]  store_waddr, store_raddr;
    tag_t            store_wdata, store_rdata;

    // datapath helpers
    logic [UW-1:0]   front_user;
    logic [CW:0]     slot_sum, slot_wrap;
    logic [UW-1:0]   ring_back;
    logic [UW-1:0]   front_inc;
    logic [QW-1:0]   m_head;
    logic [QCW-1:0]  m_cnt;
    logic [QCW-1:0]  cnt_dec;
    logic [QW:0]     pos_sum, pos_wrap;
    logic [QW-1:0]   q_pos;
    logic [QW-1:0]   head_inc;
    logic            in_accept;
    logic            out_take;

    rrjq_ram #(.WIDTH(MW), .DEPTH(MAX_USERS)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    rrjq_ram #(.WIDTH(JOB_TAG_BITS), .DEPTH(SD)) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // ring front and back slots
    always_comb
    begin
        front_user = ring_users_reg[ring_front_reg];
        slot_sum   = (CW+1)'(ring_front_reg) + (CW+1)'(ring_count_reg);
        slot_wrap  = (slot_sum >= (CW+1)'(MAX_USERS)) ? slot_sum - (CW+1)'(MAX_USERS)
                                                       : slot_sum;
        ring_back  = slot_wrap[UW-1:0];
        front_inc  = (ring_front_reg == UW'(MAX_USERS - 1)) ? '0 : ring_front_reg + 1'b1;
    end

    // per-user queue pointers; an entry never written reads as empty
    always_comb
    begin
        m_head   = rd_vld_reg ? meta_rdata[MW-1:QCW] : '0;
        m_cnt    = rd_vld_reg ? meta_rdata[QCW-1:0]  : '0;
        cnt_dec  = (m_cnt != '0) ? m_cnt - 1'b1 : m_cnt;
        pos_sum  = (QW+1)'(m_head) + (QW+1)'(m_cnt);
        pos_wrap = (pos_sum >= (QW+1)'(QUEUE_DEPTH)) ? pos_sum - (QW+1)'(QUEUE_DEPTH)
                                                      : pos_sum;
        q_pos    = pos_wrap[QW-1:0];
        head_inc = (m_head == QW'(QUEUE_DEPTH - 1)) ? '0 : m_head + 1'b1;
    end

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign out_take  = out_valid_reg && !out_stall;

    // sequencer and next-state datapath
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        cur_user_next     = cur_user_reg;
        tag_next          = tag_reg;
        stat_next         = stat_reg;
        pj_next           = pj_reg;
        hu_next           = hu_reg;
        hj_next           = hj_reg;
        rd_vld_next       = rd_vld_reg;
        vld_next          = vld_reg;
        ring_users_next   = ring_users_reg;
        ring_front_next   = ring_front_reg;
        ring_count_next   = ring_count_reg;
        out_valid_next    = out_take ? 1'b0 : out_valid_reg;
        popped_valid_next = popped_valid_reg;
        popped_job_next   = popped_job_reg;
        popped_user_next  = popped_user_reg;
        pending_next      = pending_reg;
        head_job_next     = head_job_reg;
        head_user_next    = head_user_reg;
        status_next       = status_reg;

        meta_we     = 1'b0;
        meta_re     = 1'b0;
        meta_waddr  = cur_user_reg;
        meta_raddr  = cur_user_reg;
        meta_wdata  = {m_head, m_cnt};
        store_we    = 1'b0;
        store_re    = 1'b0;
        store_waddr = store_addr(cur_user_reg, q_pos);
        store_raddr = store_addr(hu_reg, m_head);
        store_wdata = tag_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next   = op_t'(operation);
                    tag_next  = job_tag;
                    stat_next = STATUS_OK;
                    pj_next   = '0;
                    if (op_t'(operation) == OP_ADD)
                    begin
                        cur_user_next = user_index[UW-1:0];
                        if (int'(user_index) >= MAX_USERS)
                        begin
                            stat_next  = STATUS_DROP;
                            state_next = S_HRD;
                        end
                        else
                        begin
                            state_next = S_RDM;
                        end
                    end
                    else
                    begin
                        cur_user_next = front_user;
                        if (ring_count_reg == '0)
                        begin
                            stat_next  = STATUS_EMPTY;
                            state_next = S_HRD;
                        end
                        else
                        begin
                            state_next = S_RDM;
                        end
                    end
                end
            end

            // read the user's queue pointers
            S_RDM:
            begin
                meta_re     = 1'b1;
                meta_raddr  = cur_user_reg;
                rd_vld_next = vld_reg[cur_user_reg];
                state_next  = S_ACT;
            end

            // modify queue pointers and ring, write back
            S_ACT:
            begin
                if (op_reg == OP_ADD)
                begin
                    if (m_cnt >= QCW'(QUEUE_DEPTH))
                    begin
                        stat_next = STATUS_DROP;
                    end
                    else
                    begin
                        store_we   = 1'b1;
                        meta_we    = 1'b1;
                        meta_wdata = {m_head, QCW'(m_cnt + 1'b1)};
                        vld_next[cur_user_reg] = 1'b1;
                        if (m_cnt == '0)
                        begin
                            ring_users_next[ring_back] = cur_user_reg;
                            ring_count_next            = ring_count_reg + 1'b1;
                        end
                    end
                    state_next = S_HRD;
                end
                else
                begin
                    store_re    = 1'b1;
                    store_raddr = store_addr(cur_user_reg, m_head);
                    meta_we     = 1'b1;
                    meta_wdata  = {head_inc, cnt_dec};
                    vld_next[cur_user_reg] = 1'b1;
                    ring_front_next = front_inc;
                    if (cnt_dec != '0)
                    begin
                        ring_users_next[ring_back] = cur_user_reg;
                    end
                    else
                    begin
                        ring_count_next = ring_count_reg - 1'b1;
                    end
                    state_next = S_POPD;
                end
            end

            // popped job arrives from the store
            S_POPD:
            begin
                pj_next    = store_rdata;
                state_next = S_HRD;
            end

            // look up the new ring head
            S_HRD:
            begin
                if (ring_count_reg == '0)
                begin
                    hu_next    = '0;
                    hj_next    = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    meta_re     = 1'b1;
                    meta_raddr  = front_user;
                    rd_vld_next = vld_reg[front_user];
                    hu_next     = front_user;
                    state_next  = S_HMETA;
                end
            end

            S_HMETA:
            begin
                store_re    = 1'b1;
                store_raddr = store_addr(hu_reg, m_head);
                state_next  = S_HSTORE;
            end

            S_HSTORE:
            begin
                hj_next    = store_rdata;
                state_next = S_OUT;
            end

            // load the result register once it is free
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    popped_valid_next = (op_reg == OP_POP) && (stat_reg == STATUS_OK);
                    popped_job_next   = pj_reg;
                    popped_user_next  = ((op_reg == OP_POP) && (stat_reg == STATUS_OK))
                                        ? USER_BITS'(cur_user_reg) : '0;
                    pending_next      = (ring_count_reg != '0);
                    head_job_next     = hj_reg;
                    head_user_next    = USER_BITS'(hu_reg);
                    status_next       = stat_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_ADD;
            cur_user_reg     <= '0;
            tag_reg          <= '0;
            stat_reg         <= STATUS_OK;
            pj_reg           <= '0;
            hu_reg           <= '0;
            hj_reg           <= '0;
            rd_vld_reg       <= 1'b0;
            vld_reg          <= '{default: 1'b0};
            ring_front_reg   <= '0;
            ring_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
            popped_valid_reg <= 1'b0;
            popped_job_reg   <= '0;
            popped_user_reg  <= '0;
            pending_reg      <= 1'b0;
            head_job_reg     <= '0;
            head_user_reg    <= '0;
            status_reg       <= STATUS_OK;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            cur_user_reg     <= cur_user_next;
            tag_reg          <= tag_next;
            stat_reg         <= stat_next;
            pj_reg           <= pj_next;
            hu_reg           <= hu_next;
            hj_reg           <= hj_next;
            rd_vld_reg       <= rd_vld_next;
            vld_reg          <= vld_next;
            ring_front_reg   <= ring_front_next;
            ring_count_reg   <= ring_count_next;
            out_valid_reg    <= out_valid_next;
            popped_valid_reg <= popped_valid_next;
            popped_job_reg   <= popped_job_next;
            popped_user_reg  <= popped_user_next;
            pending_reg      <= pending_next;
            head_job_reg     <= head_job_next;
            head_user_reg    <= head_user_next;
            status_reg       <= status_next;
        end
    end

    // ring slots hold payload only, read only after being written
    always_ff @(posedge clk)
    begin
        ring_users_reg <= ring_users_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign popped_valid = popped_valid_reg;
    assign popped_job   = popped_job_reg;
    assign popped_user  = popped_user_reg;
    assign pending      = pending_reg;
    assign head_job     = head_job_reg;
    assign head_user    = head_user_reg;
    assign status       = status_reg;

`ifndef ASSERT_OFF
    // the ring never holds more users than exist
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(ring_count_reg) <= MAX_USERS)
    else $error("ring count exceeds user count");

    // ring occupancy changes only in the modify step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ACT) |=> $stable(ring_count_reg) && $stable(ring_front_reg))
    else $error("ring changed outside modify step");

    // a removed job is only reported with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && popped_valid_reg) |-> (status_reg == STATUS_OK))
    else $error("popped job with error status");

    // no pending work means a zero head report
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pending_reg) |-> (head_job_reg == '0) && (head_user_reg == '0))
    else $error("head reported while ring empty");
`endif

endmodule

`default_nettype wire

### hdl/rrjq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module rrjq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, data holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
